@@ src/rbem_pkg.sv @@
// ----------------------------------------------------------------------------
// rbem_pkg
// Shared types, constants and helpers of the rigid-body exponential-map step.
// ----------------------------------------------------------------------------
package rbem_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_SQRT_GO, ST_SQRT_WAIT, ST_DIV_GO,
    ST_DIV_WAIT, ST_MOD, ST_CORD_GO, ST_CORD_WAIT, ST_COMMIT, ST_OUT
  } state_t;

  typedef enum logic [2:0] {PH_HDT, PH_TRN, PH_B2, PH_R, PH_Q} phase_t;

  typedef enum logic [1:0] {SH0, SH24, SH25, SH30} shift_t;

  typedef enum logic {DS_SQRT, DS_DIV} ds_mode_t;

  typedef struct packed {
    logic signed [32:0] a;
    logic signed [32:0] b;
    shift_t             sh;
    logic               use_acc;
    logic signed [65:0] base;
  } mac_op_t;

  localparam int TWO_PI_Q16   = 411775;
  localparam int PI_Q16       = 205887;
  localparam int HALF_PI_Q16  = 102944;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [2:0] ROW_POS  = 3'd0;
  localparam logic [2:0] ROW_VEL  = 3'd1;
  localparam logic [2:0] ROW_ANGV = 3'd2;
  localparam logic [2:0] ROW_ROT0 = 3'd3;
  localparam logic [2:0] ROW_ROT1 = 3'd4;
  localparam logic [2:0] ROW_ROT2 = 3'd5;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      5'd24: v = 30'h0000003F;
      5'd25: v = 30'h0000001F;
      5'd26: v = 30'h0000000F;
      5'd27: v = 30'h00000008;
      5'd28: v = 30'h00000004;
      5'd29: v = 30'h00000002;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ src/rbem_mac.sv @@
// ----------------------------------------------------------------------------
// rbem_mac
// Shared multiply, round and accumulate unit: the product is registered, then rounded and added to the base.
// ----------------------------------------------------------------------------
module rbem_mac (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rbem_pkg::mac_op_t  op,
  output logic               done,
  output logic signed [65:0] acc
);
  import rbem_pkg::*;

  logic signed [65:0] prod;
  logic signed [65:0] base_r;
  logic signed [65:0] rnd_v;
  shift_t             sh_r;
  logic               st1;

  always_comb begin
    case (sh_r)
      SH24:    rnd_v = (prod + 66'sd8388608) >>> 24;
      SH25:    rnd_v = (prod + 66'sd16777216) >>> 25;
      SH30:    rnd_v = (prod + 66'sd536870912) >>> 30;
      default: rnd_v = prod;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1  <= 1'b0;
      done <= 1'b0;
    end else begin
      st1  <= start;
      done <= st1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod   <= $signed(op.a) * $signed(op.b);
      sh_r   <= op.sh;
      base_r <= op.use_acc ? acc : op.base;
    end
    if (st1) begin
      acc <= base_r + rnd_v;
    end
  end

endmodule

@@ src/rbem_divsqrt.sv @@
// ----------------------------------------------------------------------------
// rbem_divsqrt
// Shared shift-subtract unit: integer square root or restoring divide,
// one result bit per cycle.
// ----------------------------------------------------------------------------
module rbem_divsqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rbem_pkg::ds_mode_t mode,
  input  logic [63:0]        rad,
  input  logic [61:0]        num,
  input  logic [31:0]        den,
  output logic               done,
  output logic [31:0]        res
);
  import rbem_pkg::*;

  logic [34:0] rem;
  logic [34:0] remsh;
  logic [34:0] trial;
  logic [63:0] work;
  logic [4:0]  cnt;
  logic        busy;
  ds_mode_t    mode_r;
  logic        ge;

  always_comb begin
    if (mode_r == DS_SQRT) begin
      remsh = {rem[32:0], work[63:62]};
      trial = {1'b0, res, 2'b01};
    end else begin
      remsh = {rem[33:0], work[63]};
      trial = {3'b000, den};
    end
    ge = remsh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= mode;
      res    <= 32'd0;
      if (mode == DS_SQRT) begin
        rem  <= 35'd0;
        work <= rad;
        cnt  <= 5'd31;
      end else begin
        rem  <= {4'b0000, num[61:31]};
        work <= {num[30:0], 33'd0};
        cnt  <= 5'd30;
      end
    end else if (busy) begin
      rem  <= ge ? remsh - trial : remsh;
      res  <= {res[30:0], ge};
      work <= (mode_r == DS_SQRT) ? {work[61:0], 2'b00} : {work[62:0], 1'b0};
      cnt  <= cnt - 5'd1;
    end
  end

endmodule

@@ src/rbem_cordic.sv @@
// ----------------------------------------------------------------------------
// rbem_cordic
// Rotation-mode CORDIC, one iteration per cycle, sine and cosine in Q2.30.
// ----------------------------------------------------------------------------
module rbem_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] z_in,
  output logic               done,
  output logic signed [31:0] sn,
  output logic signed [31:0] cs
);
  import rbem_pkg::*;

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [33:0] at;
  logic [4:0]         i;
  logic               busy;

  always_comb begin
    dx = y >>> i;
    dy = x >>> i;
    at = $signed({4'b0000, atan_q30(i)});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && i == 5'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= CORDIC_GAIN;
      y <= 34'sd0;
      z <= {{2{z_in[31]}}, z_in};
      i <= 5'd0;
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
      i <= i + 5'd1;
    end
  end

  assign sn = y[31:0];
  assign cs = x[31:0];

endmodule

@@ src/rigid_body_exponential_map_step.sv @@
// ----------------------------------------------------------------------------
// rigid_body_exponential_map_step
// Products go through the shared multiply-accumulate, roots and quotients
// through the shared shift-subtract unit; the rotation update, which can be
// skipped, runs 30 CORDIC steps on the reduced angle.
// One step at a time; six rows then follow, one per transfer.
// Reset: zero position, velocity, angular velocity and stored accelerations,
// identity rotation, min_rotation_angle zero.
// ----------------------------------------------------------------------------
module rigid_body_exponential_map_step #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] lin_acc_x,
  input  logic signed [31:0] lin_acc_y,
  input  logic signed [31:0] lin_acc_z,
  input  logic signed [31:0] ang_acc_x,
  input  logic signed [31:0] ang_acc_y,
  input  logic signed [31:0] ang_acc_z,
  input  logic [23:0]        step_dt,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         row_kind,
  output logic signed [31:0] val_x,
  output logic signed [31:0] val_y,
  output logic signed [31:0] val_z,
  output logic               last_row
);
  import rbem_pkg::*;

  localparam int SAT_W = (DATA_WIDTH < 16) ? 16 : ((DATA_WIDTH > 32) ? 32 : DATA_WIDTH);
  localparam logic signed [65:0] W_HI = (66'sd1 <<< (SAT_W - 1)) - 66'sd1;
  localparam logic signed [65:0] W_LO = -W_HI - 66'sd1;
  localparam logic signed [31:0] ROT_ONE =
    (SAT_W >= 32) ? 32'sh40000000 : W_HI[31:0];

  function automatic logic signed [31:0] sat_w(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > W_HI) r = W_HI[31:0];
    else if (v < W_LO) r = W_LO[31:0];
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [32:0] sx(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic signed [65:0] bx(input logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  state_t state, state_next;
  phase_t ph;

  logic [15:0]        min_ang;
  logic [23:0]        dt;
  logic [23:0]        hdt2;
  logic signed [31:0] pos  [3];
  logic signed [31:0] vel  [3];
  logic signed [31:0] angv [3];
  logic signed [31:0] pla  [3];
  logic signed [31:0] paa  [3];
  logic signed [31:0] nla  [3];
  logic signed [31:0] naa  [3];
  logic signed [31:0] e    [3];
  logic signed [31:0] h    [3];
  logic signed [31:0] b2d  [3];
  logic signed [31:0] b2o  [3];
  logic signed [31:0] r    [9];
  logic signed [31:0] rot  [9];
  logic signed [31:0] qn   [9];
  logic [63:0]        sq;
  logic [31:0]        m;
  logic [31:0]        mr;
  logic signed [31:0] sn;
  logic signed [32:0] c1;
  logic               flip;
  logic [1:0]         ci, cj, ck;
  logic [3:0]         cn;
  logic [2:0]         row;

  logic               in_xfer, out_xfer;
  logic               mac_start, mac_done;
  logic signed [65:0] macc;
  mac_op_t            mop;
  logic               ds_start, ds_done;
  ds_mode_t           ds_mode;
  logic [31:0]        ds_res;
  logic [31:0]        mag;
  logic [61:0]        ds_num;
  logic               cord_start, cord_done;
  logic signed [31:0] cord_sn, cord_cs, cs_f;
  logic signed [31:0] z_in;
  logic signed [20:0] ang0, ang1, ang2;
  logic               flip_c;
  logic               mod_ge;
  logic [3:0]         ridx, qidx;
  logic signed [32:0] b_ent, b2_ent;
  logic signed [65:0] neg_shr;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  rbem_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .op    (mop),
    .done  (mac_done),
    .acc   (macc)
  );

  assign mag    = e[ci][31] ? 32'(-e[ci]) : 32'(e[ci]);
  assign ds_num = {mag, 30'd0} + {31'd0, m[31:1]};

  rbem_divsqrt u_ds (
    .clk   (clk),
    .rst   (rst),
    .start (ds_start),
    .mode  (ds_mode),
    .rad   (sq),
    .num   (ds_num),
    .den   (m),
    .done  (ds_done),
    .res   (ds_res)
  );

  always_comb begin
    ang0   = $signed({2'b00, mr[18:0]});
    ang1   = (ang0 > PI_Q16) ? ang0 - 21'(TWO_PI_Q16) : ang0;
    flip_c = 1'b0;
    ang2   = ang1;
    if (ang1 > HALF_PI_Q16) begin
      ang2   = 21'(PI_Q16) - ang1;
      flip_c = 1'b1;
    end else if (ang1 < -HALF_PI_Q16) begin
      ang2   = -21'(PI_Q16) - ang1;
      flip_c = 1'b1;
    end
    z_in = {{11{ang2[20]}}, ang2} <<< 14;
  end

  rbem_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .z_in  (z_in),
    .done  (cord_done),
    .sn    (cord_sn),
    .cs    (cord_cs)
  );

  assign cs_f    = flip ? -cord_cs : cord_cs;
  assign mod_ge  = mr >= (32'(TWO_PI_Q16) << cn);
  assign ridx    = {2'b00, ci} + {1'b0, ci, 1'b0} + {2'b00, ck};
  assign qidx    = {2'b00, ck} + {1'b0, ck, 1'b0} + {2'b00, cj};
  assign neg_shr = -(macc >>> 30);

  always_comb begin
    case (cn)
      4'd1:    b_ent = -sx(h[2]);
      4'd2:    b_ent = sx(h[1]);
      4'd3:    b_ent = sx(h[2]);
      4'd5:    b_ent = -sx(h[0]);
      4'd6:    b_ent = -sx(h[1]);
      4'd7:    b_ent = sx(h[0]);
      default: b_ent = 33'sd0;
    endcase
    case (cn)
      4'd0:    b2_ent = sx(b2d[0]);
      4'd1:    b2_ent = sx(b2o[0]);
      4'd2:    b2_ent = sx(b2o[1]);
      4'd3:    b2_ent = sx(b2o[0]);
      4'd4:    b2_ent = sx(b2d[1]);
      4'd5:    b2_ent = sx(b2o[2]);
      4'd6:    b2_ent = sx(b2o[1]);
      4'd7:    b2_ent = sx(b2o[2]);
      default: b2_ent = sx(b2d[2]);
    endcase
  end

  always_comb begin
    mop = '0;
    unique case (ph)
      PH_HDT: begin
        mop.a  = {9'd0, dt};
        mop.b  = {9'd0, dt};
        mop.sh = SH25;
      end
      PH_TRN: begin
        mop.sh = SH24;
        case (cn)
          4'd0: begin
            mop.a = sx(vel[ci]); mop.b = {9'd0, dt}; mop.base = bx(pos[ci]);
          end
          4'd1: begin
            mop.a = sx(pla[ci]); mop.b = {9'd0, hdt2}; mop.use_acc = 1'b1;
          end
          4'd2: begin
            mop.a = sx(pla[ci]); mop.b = {9'd0, dt}; mop.base = bx(vel[ci]);
          end
          4'd3: begin
            mop.a = sx(angv[ci]); mop.b = {9'd0, dt};
          end
          4'd4: begin
            mop.a = sx(paa[ci]); mop.b = {9'd0, hdt2}; mop.use_acc = 1'b1;
          end
          4'd5: begin
            mop.a = sx(e[ci]); mop.b = sx(e[ci]); mop.sh = SH0;
            mop.base = {2'b00, sq};
          end
          default: begin
            mop.a = sx(paa[ci]); mop.b = {9'd0, dt}; mop.base = bx(angv[ci]);
          end
        endcase
      end
      PH_B2: begin
        case (cn)
          4'd0: begin
            mop.a = sx(h[1]); mop.b = sx(h[1]); mop.base = 66'sd536870912;
          end
          4'd1: begin
            mop.a = sx(h[2]); mop.b = sx(h[2]); mop.use_acc = 1'b1;
          end
          4'd2: begin
            mop.a = sx(h[0]); mop.b = sx(h[0]); mop.base = 66'sd536870912;
          end
          4'd3: begin
            mop.a = sx(h[2]); mop.b = sx(h[2]); mop.use_acc = 1'b1;
          end
          4'd4: begin
            mop.a = sx(h[0]); mop.b = sx(h[0]); mop.base = 66'sd536870912;
          end
          4'd5: begin
            mop.a = sx(h[1]); mop.b = sx(h[1]); mop.use_acc = 1'b1;
          end
          4'd6: begin
            mop.a = sx(h[0]); mop.b = sx(h[1]); mop.sh = SH30;
          end
          4'd7: begin
            mop.a = sx(h[0]); mop.b = sx(h[2]); mop.sh = SH30;
          end
          default: begin
            mop.a = sx(h[1]); mop.b = sx(h[2]); mop.sh = SH30;
          end
        endcase
      end
      PH_R: begin
        mop.sh = SH30;
        if (ck == 2'd0) begin
          mop.a = b_ent;
          mop.b = sx(sn);
          if (cn == 4'd0 || cn == 4'd4 || cn == 4'd8) mop.base = 66'sd1073741824;
        end else begin
          mop.a       = b2_ent;
          mop.b       = c1;
          mop.use_acc = 1'b1;
        end
      end
      PH_Q: begin
        mop.a       = sx(r[ridx]);
        mop.b       = sx(rot[qidx]);
        mop.sh      = SH30;
        mop.use_acc = (ck != 2'd0);
      end
      default: mop = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mac_start  = 1'b0;
    ds_start   = 1'b0;
    ds_mode    = DS_SQRT;
    cord_start = 1'b0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        mac_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_next = ST_ISSUE;
          if (ph == PH_TRN && cn == 4'd6 && ci == 2'd2) state_next = ST_SQRT_GO;
          if (ph == PH_Q && cn == 4'd8 && ck == 2'd2) state_next = ST_COMMIT;
        end
      end
      ST_SQRT_GO: begin
        ds_start   = 1'b1;
        state_next = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (ds_done) state_next = (ds_res > {16'd0, min_ang}) ? ST_DIV_GO : ST_OUT;
      end
      ST_DIV_GO: begin
        ds_start   = 1'b1;
        ds_mode    = DS_DIV;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (ds_done) state_next = (ci == 2'd2) ? ST_MOD : ST_DIV_GO;
      end
      ST_MOD: begin
        if (cn == 4'd0) state_next = ST_CORD_GO;
      end
      ST_CORD_GO: begin
        cord_start = 1'b1;
        state_next = ST_CORD_WAIT;
      end
      ST_CORD_WAIT: begin
        if (cord_done) state_next = ST_ISSUE;
      end
      ST_COMMIT: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall && row == ROW_ROT2) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_ang <= 16'd0;
      ph      <= PH_HDT;
      row     <= ROW_POS;
      ci      <= 2'd0;
      cj      <= 2'd0;
      ck      <= 2'd0;
      cn      <= 4'd0;
      for (int i = 0; i < 3; i++) begin
        pos[i]  <= 32'sd0;
        vel[i]  <= 32'sd0;
        angv[i] <= 32'sd0;
        pla[i]  <= 32'sd0;
        paa[i]  <= 32'sd0;
      end
      for (int i = 0; i < 9; i++) begin
        rot[i] <= (i % 4 == 0) ? ROT_ONE : 32'sd0;
      end
    end else begin
      if (cfg_wr_en) min_ang <= cfg_wr_data;
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            dt     <= step_dt;
            nla[0] <= lin_acc_x;
            nla[1] <= lin_acc_y;
            nla[2] <= lin_acc_z;
            naa[0] <= ang_acc_x;
            naa[1] <= ang_acc_y;
            naa[2] <= ang_acc_z;
            sq     <= 64'd0;
            ph     <= PH_HDT;
          end
        end
        ST_WAIT: begin
          if (mac_done) begin
            unique case (ph)
              PH_HDT: begin
                hdt2 <= macc[23:0];
                ph   <= PH_TRN;
                ci   <= 2'd0;
                cn   <= 4'd0;
              end
              PH_TRN: begin
                case (cn)
                  4'd1: pos[ci]  <= sat_w(macc);
                  4'd2: vel[ci]  <= sat_w(macc);
                  4'd4: e[ci]    <= sat32(macc);
                  4'd5: sq       <= macc[63:0];
                  4'd6: angv[ci] <= sat_w(macc);
                  default: ;
                endcase
                if (cn == 4'd6) begin
                  cn <= 4'd0;
                  ci <= ci + 2'd1;
                end else begin
                  cn <= cn + 4'd1;
                end
              end
              PH_B2: begin
                case (cn)
                  4'd1: b2d[0] <= neg_shr[31:0];
                  4'd3: b2d[1] <= neg_shr[31:0];
                  4'd5: b2d[2] <= neg_shr[31:0];
                  4'd6: b2o[0] <= macc[31:0];
                  4'd7: b2o[1] <= macc[31:0];
                  4'd8: b2o[2] <= macc[31:0];
                  default: ;
                endcase
                if (cn == 4'd8) begin
                  ph <= PH_R;
                  cn <= 4'd0;
                  ck <= 2'd0;
                end else begin
                  cn <= cn + 4'd1;
                end
              end
              PH_R: begin
                if (ck == 2'd1) begin
                  r[cn] <= sat32(macc);
                  ck    <= 2'd0;
                  if (cn == 4'd8) begin
                    ph <= PH_Q;
                    cn <= 4'd0;
                    ci <= 2'd0;
                    cj <= 2'd0;
                  end else begin
                    cn <= cn + 4'd1;
                  end
                end else begin
                  ck <= 2'd1;
                end
              end
              PH_Q: begin
                if (ck == 2'd2) begin
                  qn[cn] <= sat_w(macc);
                  ck     <= 2'd0;
                  cn     <= cn + 4'd1;
                  if (cj == 2'd2) begin
                    cj <= 2'd0;
                    ci <= ci + 2'd1;
                  end else begin
                    cj <= cj + 2'd1;
                  end
                end else begin
                  ck <= ck + 2'd1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SQRT_WAIT: begin
          if (ds_done) begin
            m  <= ds_res;
            ci <= 2'd0;
          end
        end
        ST_DIV_WAIT: begin
          if (ds_done) begin
            h[ci] <= e[ci][31] ? -$signed(ds_res) : $signed(ds_res);
            ci    <= ci + 2'd1;
            cn    <= 4'd13;
            mr    <= m;
          end
        end
        ST_MOD: begin
          if (mod_ge) mr <= mr - (32'(TWO_PI_Q16) << cn);
          cn <= cn - 4'd1;
        end
        ST_CORD_GO: begin
          flip <= flip_c;
        end
        ST_CORD_WAIT: begin
          if (cord_done) begin
            sn <= cord_sn;
            c1 <= 33'sh040000000 - sx(cs_f);
            ph <= PH_B2;
            cn <= 4'd0;
          end
        end
        ST_COMMIT: begin
          for (int i = 0; i < 9; i++) rot[i] <= qn[i];
        end
        ST_OUT: begin
          for (int i = 0; i < 3; i++) begin
            pla[i] <= nla[i];
            paa[i] <= naa[i];
          end
          if (out_xfer) row <= (row == ROW_ROT2) ? ROW_POS : row + 3'd1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    row_kind = row;
    last_row = (row == ROW_ROT2);
    unique case (row)
      ROW_VEL:  begin val_x = vel[0];  val_y = vel[1];  val_z = vel[2];  end
      ROW_ANGV: begin val_x = angv[0]; val_y = angv[1]; val_z = angv[2]; end
      ROW_ROT0: begin val_x = rot[0];  val_y = rot[1];  val_z = rot[2];  end
      ROW_ROT1: begin val_x = rot[3];  val_y = rot[4];  val_z = rot[5];  end
      ROW_ROT2: begin val_x = rot[6];  val_y = rot[7];  val_z = rot[8];  end
      default:  begin val_x = pos[0];  val_y = pos[1];  val_z = pos[2];  end
    endcase
  end

endmodule

@@ tb/tb_rigid_body_exponential_map_step.sv @@
// ----------------------------------------------------------------------------
// tb_rigid_body_exponential_map_step
// Self-checking bench for the rigid-body exponential-map integrator step.
// Steps get random idle on both sides, save in the last phase. A bit-exact
// fixed-point model of the integrator predicts the six rows of each step;
// each row is checked in order; the rotation threshold changes per phase.
// ----------------------------------------------------------------------------
module tb_rigid_body_exponential_map_step;
  timeunit 1ns;
  timeprecision 1ps;
  import rbem_pkg::*;

  localparam int DW          = 32;
  localparam int STALL_LIMIT = 40000;
  localparam int N_PHASE     = 35;

  typedef struct {
    logic signed [31:0] lin [3];
    logic signed [31:0] ang [3];
    logic [23:0]        dt;
  } step_t;

  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] x, y, z;
    logic               last;
  } row_t;

  class integrator_board;
    longint      prev_lin [3], prev_ang [3], pos [3], vel [3], angv [3], rot [9];
    longint      threshold;
    longint      atan_tab [30];
    row_t        rows_due [$];
    int          rotations;

    function new();
      atan_tab = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
      threshold = 0;
      rotations = 0;
      for (int i = 0; i < 3; i++) begin
        prev_lin[i] = 0; prev_ang[i] = 0; pos[i] = 0; vel[i] = 0; angv[i] = 0;
      end
      for (int i = 0; i < 9; i++) rot[i] = (i % 4 == 0) ? sat(64'sd1 << 30, DW) : 0;
    endfunction

    function longint rnd(longint v, int s);
      return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function longint sat(longint v, int w);
      longint hi, lo;
      if (w < 16) w = 16;
      if (w > 32) w = 32;
      hi = (64'sd1 << (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function longint root(longint unsigned s);
      longint unsigned r, t;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= s) r = t;
      end
      return longint'(r);
    endfunction

    function void spin(longint e [3], longint m);
      longint h [3], b [9], b2 [9], r [9], q [9];
      longint mag, v, ang, x, y, z, dx, dy, c1, acc;
      bit     flip;
      flip = 0;
      for (int i = 0; i < 3; i++) begin
        mag  = e[i] < 0 ? -e[i] : e[i];
        v    = ((mag << 30) + m / 2) / m;
        h[i] = e[i] < 0 ? -v : v;
      end
      ang = m % TWO_PI_Q16;
      if (ang > PI_Q16) ang -= TWO_PI_Q16;
      if (ang > HALF_PI_Q16) begin
        ang = PI_Q16 - ang; flip = 1;
      end else if (ang < -HALF_PI_Q16) begin
        ang = -PI_Q16 - ang; flip = 1;
      end
      z = ang * 16384; x = CORDIC_GAIN; y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i; dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      if (flip) x = -x;
      c1 = (64'sd1 << 30) - x;
      b = '{0, -h[2], h[1], h[2], 0, -h[0], -h[1], h[0], 0};
      b2[0] = -rnd(h[1] * h[1] + h[2] * h[2], 30);
      b2[4] = -rnd(h[0] * h[0] + h[2] * h[2], 30);
      b2[8] = -rnd(h[0] * h[0] + h[1] * h[1], 30);
      b2[1] = rnd(h[0] * h[1], 30); b2[3] = b2[1];
      b2[2] = rnd(h[0] * h[2], 30); b2[6] = b2[2];
      b2[5] = rnd(h[1] * h[2], 30); b2[7] = b2[5];
      for (int i = 0; i < 9; i++)
        r[i] = sat(((i % 4 == 0) ? (64'sd1 << 30) : 0) + rnd(b[i] * y, 30)
                   + rnd(b2[i] * c1, 30), 32);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += rnd(r[i*3+k] * rot[k*3+j], 30);
          q[i*3+j] = sat(acc, DW);
        end
      rot = q;
      rotations++;
    endfunction

    function void push_row(logic [2:0] kind, longint a, longint b, longint c);
      row_t r;
      r.kind = kind; r.x = a[31:0]; r.y = b[31:0]; r.z = c[31:0];
      r.last = (kind == ROW_ROT2);
      rows_due.push_back(r);
    endfunction

    function void note_step(step_t s);
      longint dt, hdt2, w, e [3];
      longint unsigned sq, mg;
      longint m;
      dt   = s.dt;
      hdt2 = (dt * dt + (64'sd1 << 24)) >>> 25;
      sq   = 0;
      for (int i = 0; i < 3; i++) begin
        w       = angv[i];
        pos[i]  = sat(pos[i] + rnd(vel[i] * dt, 24) + rnd(prev_lin[i] * hdt2, 24), DW);
        vel[i]  = sat(vel[i] + rnd(prev_lin[i] * dt, 24), DW);
        e[i]    = sat(rnd(w * dt, 24) + rnd(prev_ang[i] * hdt2, 24), 32);
        angv[i] = sat(w + rnd(prev_ang[i] * dt, 24), DW);
        mg      = e[i] < 0 ? -e[i] : e[i];
        sq     += mg * mg;
      end
      m = root(sq);
      if (m > threshold) spin(e, m);
      for (int i = 0; i < 3; i++) begin
        prev_lin[i] = s.lin[i];
        prev_ang[i] = s.ang[i];
      end
      push_row(ROW_POS,  pos[0],  pos[1],  pos[2]);
      push_row(ROW_VEL,  vel[0],  vel[1],  vel[2]);
      push_row(ROW_ANGV, angv[0], angv[1], angv[2]);
      push_row(ROW_ROT0, rot[0], rot[1], rot[2]);
      push_row(ROW_ROT1, rot[3], rot[4], rot[5]);
      push_row(ROW_ROT2, rot[6], rot[7], rot[8]);
    endfunction

    function string check_row(row_t got);
      row_t exp_r;
      if (rows_due.size() == 0)
        return $sformatf("unexpected row kind %0d", got.kind);
      exp_r = rows_due.pop_front();
      if (got.kind !== exp_r.kind || got.x !== exp_r.x || got.y !== exp_r.y ||
          got.z !== exp_r.z || got.last !== exp_r.last)
        return $sformatf("row %0d/%0d: got %0d %0d %0d last %0d, want %0d %0d %0d last %0d",
                         got.kind, exp_r.kind, got.x, got.y, got.z, got.last,
                         exp_r.x, exp_r.y, exp_r.z, exp_r.last);
      return "";
    endfunction
  endclass

  logic               clk, rst, cfg_wr_en, in_valid, in_stall, out_valid, out_stall;
  logic [15:0]        cfg_wr_data;
  logic signed [31:0] lin_acc_x, lin_acc_y, lin_acc_z, ang_acc_x, ang_acc_y, ang_acc_z;
  logic [23:0]        step_dt;
  logic [2:0]         row_kind;
  logic signed [31:0] val_x, val_y, val_z;
  logic               last_row;

  integrator_board board;
  int              errors, rows_seen, steps_sent, idle_cycles;
  int              send_pct, recv_pct;

  rigid_body_exponential_map_step #(.DATA_WIDTH(DW)) u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .lin_acc_x(lin_acc_x), .lin_acc_y(lin_acc_y), .lin_acc_z(lin_acc_z),
    .ang_acc_x(ang_acc_x), .ang_acc_y(ang_acc_y), .ang_acc_z(ang_acc_z),
    .step_dt(step_dt), .out_valid(out_valid), .out_stall(out_stall),
    .row_kind(row_kind), .val_x(val_x), .val_y(val_y), .val_z(val_z),
    .last_row(last_row)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    row_t  r;
    string msg;
    if (!rst && out_valid && !out_stall) begin
      r.kind = row_kind; r.x = val_x; r.y = val_y; r.z = val_z; r.last = last_row;
      msg = board.check_row(r);
      rows_seen++;
      if (msg != "") report(msg);
    end
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < recv_pct);

  task automatic write_threshold(logic [15:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    board.threshold = v;
  endtask

  task automatic send_step(step_t s);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    lin_acc_x <= s.lin[0]; lin_acc_y <= s.lin[1]; lin_acc_z <= s.lin[2];
    ang_acc_x <= s.ang[0]; ang_acc_y <= s.ang[1]; ang_acc_z <= s.ang[2];
    step_dt   <= s.dt;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_step(s);
    steps_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.rows_due.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_acc();
    case ($urandom_range(0, 4))
      0, 1:    return $urandom;
      2:       return $signed($urandom_range(0, 32'h001FFFFF)) - 32'sh00100000;
      3:       return $signed($urandom_range(0, 32'h0001FFFF)) - 32'sh00010000;
      default: return 0;
    endcase
  endfunction

  function automatic step_t rand_step();
    step_t s;
    for (int i = 0; i < 3; i++) begin
      s.lin[i] = rand_acc();
      s.ang[i] = rand_acc();
    end
    case ($urandom_range(0, 3))
      0:       s.dt = $urandom;
      1:       s.dt = $urandom_range(0, 24'h00FFFF);
      2:       s.dt = 24'hFFFFFF;
      default: s.dt = $urandom_range(0, 24'h1FFFFF);
    endcase
    return s;
  endfunction

  function automatic step_t mk(logic signed [31:0] la, logic signed [31:0] aa,
                                logic [23:0] dt);
    step_t s;
    s.lin = '{la, -la, la}; s.ang = '{aa, aa >>> 1, -aa}; s.dt = dt;
    return s;
  endfunction

  initial begin
    step_t dir [$];
    board = new();
    errors = 0; rows_seen = 0; steps_sent = 0; idle_cycles = 0;
    send_pct = 36; recv_pct = 87;
    rst = 1; cfg_wr_en = 0; cfg_wr_data = 0; in_valid = 0; out_stall = 0;
    lin_acc_x = 0; lin_acc_y = 0; lin_acc_z = 0;
    ang_acc_x = 0; ang_acc_y = 0; ang_acc_z = 0; step_dt = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    write_threshold(16'd0);
    dir = '{mk(0, 0, 0), mk(0, 0, 24'hFFFFFF), mk(32'sh00010000, 32'sh00008000, 24'h400000),
            mk(32'sh00010000, 32'sh00008000, 24'h400000), mk(0, 0, 24'h800000),
            mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'hFFFFFF),
            mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'hFFFFFF),
            mk(32'sh80000000, 32'sh80000000, 24'hFFFFFF),
            mk(32'sh80000000, 32'sh80000000, 24'hFFFFFF),
            mk(32'sh80000000, 32'sh80000000, 24'h000001), mk(0, 0, 24'h000001),
            mk(32'sh00000001, 32'sh00000001, 24'hFFFFFF), mk(-1, -1, 24'h7FFFFF),
            mk(32'sh00030000, 32'sh00064000, 24'hFFFFFF), mk(0, 0, 24'hFFFFFF),
            mk(0, 0, 24'hFFFFFF), mk(32'sh12345678, 32'shEDCBA987, 24'hA5A5A5),
            mk(0, 0, 24'h5A5A5A)};
    foreach (dir[i]) send_step(dir[i]);
    repeat (N_PHASE - 10) send_step(rand_step());
    drain();

    write_threshold(16'hFFFF);
    send_pct = 87; recv_pct = 36;
    repeat (N_PHASE) send_step(rand_step());
    drain();

    write_threshold($urandom_range(0, 16'hFFFF));
    send_pct = 0; recv_pct = 0;
    repeat (N_PHASE) send_step(rand_step());
    drain();

    $display("Ran %0d steps over three thresholds and idle mixes; %0d rows checked.",
             steps_sent, rows_seen);
    $display("Rotation updates applied: %0d; mismatches: %0d.", board.rotations, errors);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
